FILE: rtl/rtcpt_pkg.sv
package rtcpt_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register offsets
  localparam logic [4:0] OFF_CTRLA       = 5'd0;
  localparam logic [4:0] OFF_STATUS      = 5'd1;
  localparam logic [4:0] OFF_INTCTRL     = 5'd2;
  localparam logic [4:0] OFF_INTFLAGS    = 5'd3;
  localparam logic [4:0] OFF_CLKSEL      = 5'd7;
  localparam logic [4:0] OFF_CNTL        = 5'd8;
  localparam logic [4:0] OFF_CNTH        = 5'd9;
  localparam logic [4:0] OFF_PERL        = 5'd10;
  localparam logic [4:0] OFF_PERH        = 5'd11;
  localparam logic [4:0] OFF_CMPL        = 5'd12;
  localparam logic [4:0] OFF_CMPH        = 5'd13;
  localparam logic [4:0] OFF_PITCTRLA    = 5'd16;
  localparam logic [4:0] OFF_PITSTATUS   = 5'd17;
  localparam logic [4:0] OFF_PITINTCTRL  = 5'd18;
  localparam logic [4:0] OFF_PITINTFLAGS = 5'd19;

  // field masks and limits
  localparam logic [7:0] PRESC_FIELD    = 8'h78;
  localparam logic [1:0] OVF_BIT        = 2'h1;
  localparam logic [1:0] CMP_BIT        = 2'h2;
  localparam logic [1:0] BOTH_BITS      = 2'h3;
  localparam logic [3:0] PIT_MAX_PERIOD = 4'd14;
  localparam logic [7:0] BYTE_MASK      = 8'hff;

  // sync-busy timers
  localparam int NUM_BUSY = 5;
  localparam logic [1:0] BUSY_TICKS = 2'd2;
  localparam int TMR_CTRLA = 0;
  localparam int TMR_CNT   = 1;
  localparam int TMR_PER   = 2;
  localparam int TMR_CMP   = 3;
  localparam int TMR_PIT   = 4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] reg_offset;
    logic [7:0] write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       counter_irq;
    logic       periodic_irq;
  } result_t;

endpackage

FILE: rtl/rtcpt_in_stage.sv
module rtcpt_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rtcpt_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output rtcpt_pkg::item_t item
);
  import rtcpt_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  // register is free when empty or when its transaction moves on
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/rtcpt_core.sv
module rtcpt_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  rtcpt_pkg::item_t   item,
  output rtcpt_pkg::result_t res
);
  import rtcpt_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [7:0]            ctrla_r, ctrla_nxt;
  logic [1:0]            clksel_r, clksel_nxt;
  logic [1:0]            inten_r, inten_nxt;
  logic [1:0]            flags_r, flags_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] per_r, per_nxt;
  logic [COUNT_BITS-1:0] cmp_r, cmp_nxt;
  logic [14:0]           pphase_r, pphase_nxt;
  logic [7:0]            hlatch_r, hlatch_nxt;
  logic [7:0]            pitctrl_r, pitctrl_nxt;
  logic                  piten_r, piten_nxt;
  logic                  pitflag_r, pitflag_nxt;
  logic [14:0]           pitphase_r, pitphase_nxt;
  logic [1:0]            busy_r   [NUM_BUSY];
  logic [1:0]            busy_nxt [NUM_BUSY];

  logic [15:0]           cnt_ext, per_ext, cmp_ext;
  logic [15:0]           cnt_set16, per_set16, cmp_set16;
  logic [COUNT_BITS-1:0] cnt_set;
  logic [15:0]           cnt_set_ext;
  logic [COUNT_BITS-1:0] cnt_step;
  logic                  step_wrap;
  logic                  step_cmp;
  logic [3:0]            presc;
  logic [15:0]           pphase_inc, presc_lim;
  logic [3:0]            pit_per;
  logic                  pit_run;
  logic [15:0]           pitphase_inc, pit_lim;
  logic [7:0]            rd;

  function automatic logic [15:0] set_byte(input logic [15:0] word, input logic high,
                                           input logic [7:0] b);
    logic [15:0] w;
    if (high) begin
      w = {b, word[7:0]};
    end else begin
      w = {word[15:8], b};
    end
    return w;
  endfunction

  // byte views of the counter registers
  assign cnt_ext = 16'(cnt_r);
  assign per_ext = 16'(per_r);
  assign cmp_ext = 16'(cmp_r);

  assign cnt_set16   = set_byte(cnt_ext, item.reg_offset == OFF_CNTH, item.write_byte);
  assign per_set16   = set_byte(per_ext, item.reg_offset == OFF_PERH, item.write_byte);
  assign cmp_set16   = set_byte(cmp_ext, item.reg_offset == OFF_CMPH, item.write_byte);
  assign cnt_set     = cnt_set16[COUNT_BITS-1:0];
  assign cnt_set_ext = 16'(cnt_set);

  // one counter step: wrap at top, compare against the new value
  assign step_wrap = cnt_r >= per_r;
  assign cnt_step  = step_wrap ? '0 : cnt_r + CNT_ONE;
  assign step_cmp  = (cnt_step == cmp_r) && (cmp_r <= per_r);

  // prescaler terminal count
  assign presc      = 4'((ctrla_r & PRESC_FIELD) >> 3);
  assign pphase_inc = {1'b0, pphase_r} + 16'd1;
  assign presc_lim  = 16'd1 << presc;

  // periodic timer terminal count
  assign pit_per      = 4'((pitctrl_r & PRESC_FIELD) >> 3);
  assign pit_run      = pitctrl_r[0] && (pit_per >= 4'd1) && (pit_per <= PIT_MAX_PERIOD);
  assign pitphase_inc = {1'b0, pitphase_r} + 16'd1;
  assign pit_lim      = 16'd1 << ({1'b0, pit_per} + 5'd1);

  // next state and read data for the current transaction
  always_comb begin
    ctrla_nxt    = ctrla_r;
    clksel_nxt   = clksel_r;
    inten_nxt    = inten_r;
    flags_nxt    = flags_r;
    cnt_nxt      = cnt_r;
    per_nxt      = per_r;
    cmp_nxt      = cmp_r;
    pphase_nxt   = pphase_r;
    hlatch_nxt   = hlatch_r;
    pitctrl_nxt  = pitctrl_r;
    piten_nxt    = piten_r;
    pitflag_nxt  = pitflag_r;
    pitphase_nxt = pitphase_r;
    for (int i = 0; i < NUM_BUSY; i++) begin
      busy_nxt[i] = busy_r[i];
    end
    rd = 8'h00;

    case (item.cmd)
      CMD_TICK: begin
        for (int i = 0; i < NUM_BUSY; i++) begin
          if (busy_r[i] != 2'd0) begin
            busy_nxt[i] = busy_r[i] - 2'd1;
          end
        end
        if (ctrla_r[0]) begin
          if (pphase_inc >= presc_lim) begin
            pphase_nxt = '0;
            cnt_nxt    = cnt_step;
            if (step_wrap) begin
              flags_nxt = flags_nxt | OVF_BIT;
            end
            if (step_cmp) begin
              flags_nxt = flags_nxt | CMP_BIT;
            end
          end else begin
            pphase_nxt = pphase_inc[14:0];
          end
        end
        if (pit_run) begin
          if (pitphase_inc >= pit_lim) begin
            pitphase_nxt = '0;
            pitflag_nxt  = 1'b1;
          end else begin
            pitphase_nxt = pitphase_inc[14:0];
          end
        end
      end
      CMD_WRITE: begin
        case (item.reg_offset)
          OFF_CTRLA: begin
            ctrla_nxt           = item.write_byte;
            busy_nxt[TMR_CTRLA] = BUSY_TICKS;
            pphase_nxt          = '0;
          end
          OFF_INTCTRL: begin
            inten_nxt = item.write_byte[1:0] & BOTH_BITS;
          end
          OFF_INTFLAGS: begin
            flags_nxt = flags_r & ~item.write_byte[1:0] & BOTH_BITS;
          end
          OFF_CLKSEL: begin
            clksel_nxt   = item.write_byte[1:0];
            pphase_nxt   = '0;
            pitphase_nxt = '0;
          end
          OFF_CNTL, OFF_CNTH: begin
            cnt_nxt           = cnt_set;
            hlatch_nxt        = cnt_set_ext[15:8];
            busy_nxt[TMR_CNT] = BUSY_TICKS;
            pphase_nxt        = '0;
          end
          OFF_PERL, OFF_PERH: begin
            per_nxt           = per_set16[COUNT_BITS-1:0];
            busy_nxt[TMR_PER] = BUSY_TICKS;
            pphase_nxt        = '0;
          end
          OFF_CMPL, OFF_CMPH: begin
            cmp_nxt           = cmp_set16[COUNT_BITS-1:0];
            busy_nxt[TMR_CMP] = BUSY_TICKS;
            pphase_nxt        = '0;
          end
          OFF_PITCTRLA: begin
            pitctrl_nxt       = item.write_byte;
            busy_nxt[TMR_PIT] = BUSY_TICKS;
            pitphase_nxt      = '0;
          end
          OFF_PITINTCTRL: begin
            piten_nxt = item.write_byte[0];
          end
          OFF_PITINTFLAGS: begin
            if (item.write_byte[0]) begin
              pitflag_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_READ: begin
        case (item.reg_offset)
          OFF_CTRLA:    rd = ctrla_r;
          OFF_STATUS: begin
            rd = {4'h0, busy_r[TMR_CMP] != 2'd0, busy_r[TMR_PER] != 2'd0,
                  busy_r[TMR_CNT] != 2'd0, busy_r[TMR_CTRLA] != 2'd0};
          end
          OFF_INTCTRL:  rd = {6'h00, inten_r};
          OFF_INTFLAGS: rd = {6'h00, flags_r};
          OFF_CLKSEL:   rd = {6'h00, clksel_r};
          OFF_CNTL: begin
            hlatch_nxt = cnt_ext[15:8];
            rd         = cnt_ext[7:0] & BYTE_MASK;
          end
          OFF_CNTH:        rd = hlatch_r;
          OFF_PERL:        rd = per_ext[7:0];
          OFF_PERH:        rd = per_ext[15:8];
          OFF_CMPL:        rd = cmp_ext[7:0];
          OFF_CMPH:        rd = cmp_ext[15:8];
          OFF_PITCTRLA:    rd = pitctrl_r;
          OFF_PITSTATUS:   rd = {7'h00, busy_r[TMR_PIT] != 2'd0};
          OFF_PITINTCTRL:  rd = {7'h00, piten_r};
          OFF_PITINTFLAGS: rd = {7'h00, pitflag_r};
          default:         rd = 8'h00;
        endcase
      end
      default: begin
      end
    endcase
  end

  // result reflects the state after the transaction
  always_comb begin
    res.read_byte    = rd;
    res.counter_irq  = |(flags_nxt & inten_nxt);
    res.periodic_irq = piten_nxt && pitflag_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrla_r    <= '0;
      clksel_r   <= '0;
      inten_r    <= '0;
      flags_r    <= '0;
      cnt_r      <= '0;
      per_r      <= '1;
      cmp_r      <= '0;
      pphase_r   <= '0;
      hlatch_r   <= '0;
      pitctrl_r  <= '0;
      piten_r    <= 1'b0;
      pitflag_r  <= 1'b0;
      pitphase_r <= '0;
      for (int i = 0; i < NUM_BUSY; i++) begin
        busy_r[i] <= '0;
      end
    end else if (en) begin
      ctrla_r    <= ctrla_nxt;
      clksel_r   <= clksel_nxt;
      inten_r    <= inten_nxt;
      flags_r    <= flags_nxt;
      cnt_r      <= cnt_nxt;
      per_r      <= per_nxt;
      cmp_r      <= cmp_nxt;
      pphase_r   <= pphase_nxt;
      hlatch_r   <= hlatch_nxt;
      pitctrl_r  <= pitctrl_nxt;
      piten_r    <= piten_nxt;
      pitflag_r  <= pitflag_nxt;
      pitphase_r <= pitphase_nxt;
      for (int i = 0; i < NUM_BUSY; i++) begin
        busy_r[i] <= busy_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  // a ctrla write arms its busy timer
  a_ctrla_busy: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.cmd == CMD_WRITE && item.reg_offset == OFF_CTRLA
    |=> busy_r[TMR_CTRLA] == BUSY_TICKS)
    else $error("ctrla write did not arm busy timer");

  // no transaction, no change of counter or flags
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cnt_r) && $stable(flags_r) && $stable(pitflag_r))
    else $error("state changed without a transaction");

  // pit flag is only raised by a tick
  a_pit_flag_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pitflag_r) |-> $past(en && item.cmd == CMD_TICK && pit_run))
    else $error("pit flag set outside a running tick");

  // overflow flag is only raised by a tick with the counter enabled
  a_ovf_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(flags_r[0]) |-> $past(en && item.cmd == CMD_TICK && ctrla_r[0]))
    else $error("overflow flag set outside an enabled tick");
`endif

endmodule

FILE: rtl/rtc_counter_with_periodic_timer_top.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_cmd, in_reg_offset, in_write_byte
// out      output     out_valid/out_stall out_read_byte, out_counter_irq, out_periodic_irq
//
// one transaction per clock sustained while the result is not stalled; the result passes
// through the input register, then a single-pass state update into the result register
// the state update is combinational compares and increments in the core
// synchronous active-low reset clears all control state; no clearing pass
// a stalled result holds the pipe; the input register still takes one
// transaction while the result waits
module rtc_counter_with_periodic_timer_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_reg_offset,
  input  logic [7:0] in_write_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_byte,
  output logic       out_counter_irq,
  output logic       out_periodic_irq
);
  import rtcpt_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;

  assign in_item = '{cmd: in_cmd, reg_offset: in_reg_offset, write_byte: in_write_byte};

  // the held transaction moves on when the result register is free
  assign advance = item_valid && (!out_valid_r || !out_stall);

  rtcpt_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rtcpt_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (item),
    .res   (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_byte    = res_r.read_byte;
  assign out_counter_irq  = res_r.counter_irq;
  assign out_periodic_irq = res_r.periodic_irq;

endmodule

FILE: tb/tb_rtc_counter_with_periodic_timer_top.sv
`timescale 1ns / 100ps

module tb_rtc_counter_with_periodic_timer_top;
  import rtcpt_pkg::*;

  localparam int CNT_W = 16;
  localparam int RANDOM_ITEMS = 525;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [4:0] OFF_UNUSED_LO = 5'd5;
  localparam logic [4:0] OFF_UNUSED_HI = 5'd31;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd = CMD_TICK;
  logic [4:0] in_reg_offset = OFF_CTRLA;
  logic [7:0] in_write_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_byte;
  logic       out_counter_irq;
  logic       out_periodic_irq;

  rtc_counter_with_periodic_timer_top #(
    .COUNT_BITS(CNT_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_reg_offset   (in_reg_offset),
    .in_write_byte   (in_write_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_byte   (out_read_byte),
    .out_counter_irq (out_counter_irq),
    .out_periodic_irq(out_periodic_irq)
  );

  // shadow copy of the timer state
  logic [7:0]  ctrl_a;
  logic [1:0]  clk_sel;
  logic [1:0]  irq_enables;
  logic [1:0]  irq_flags;
  logic [15:0] count_now;
  logic [15:0] count_top;
  logic [15:0] count_cmp;
  int          presc_phase;
  logic [7:0]  cnt_hi_latch;
  logic [7:0]  pit_ctrl;
  logic [1:0]  pit_en_flag;
  int          pit_phase;
  logic [1:0]  busy_left [NUM_BUSY];

  item_t   pending_items [$];
  result_t expected_results [$];
  int      n_accepted = 0;
  int      n_errors = 0;
  int      idle_cycles = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void rtc_state_reset();
    ctrl_a = '0;
    clk_sel = '0;
    irq_enables = '0;
    irq_flags = '0;
    count_now = '0;
    count_top = '1;
    count_cmp = '0;
    presc_phase = 0;
    cnt_hi_latch = '0;
    pit_ctrl = '0;
    pit_en_flag = '0;
    pit_phase = 0;
    for (int i = 0; i < NUM_BUSY; i++) busy_left[i] = '0;
  endfunction

  // advance the shadow state by one transaction and return its result
  function automatic result_t rtc_apply(input item_t it);
    result_t r;
    int      presc;
    int      pit_per;
    logic [7:0] b;
    r = '0;
    b = it.write_byte;
    case (it.cmd)
      CMD_TICK: begin
        for (int i = 0; i < NUM_BUSY; i++)
          if (busy_left[i] != 0) busy_left[i] = busy_left[i] - 2'd1;
        // prescaled counter step
        if (ctrl_a[0]) begin
          presc = int'((ctrl_a & PRESC_FIELD) >> 3);
          if (presc_phase + 1 >= (1 << presc)) begin
            presc_phase = 0;
            if (count_now >= count_top) begin
              count_now = '0;
              irq_flags = irq_flags | OVF_BIT;
            end else begin
              count_now = count_now + 16'd1;
            end
            if (count_now == count_cmp && count_cmp <= count_top)
              irq_flags = irq_flags | CMP_BIT;
          end else begin
            presc_phase++;
          end
        end
        // periodic timer
        pit_per = int'((pit_ctrl & PRESC_FIELD) >> 3);
        if (pit_ctrl[0] && pit_per >= 1 && pit_per <= int'(PIT_MAX_PERIOD)) begin
          if (pit_phase + 1 >= (1 << (pit_per + 1))) begin
            pit_phase = 0;
            pit_en_flag[1] = 1'b1;
          end else begin
            pit_phase++;
          end
        end
      end
      CMD_WRITE: begin
        case (it.reg_offset)
          OFF_CTRLA: begin
            ctrl_a = b;
            busy_left[TMR_CTRLA] = BUSY_TICKS;
            presc_phase = 0;
          end
          OFF_INTCTRL: irq_enables = b[1:0] & BOTH_BITS;
          OFF_INTFLAGS: irq_flags = irq_flags & ~b[1:0] & BOTH_BITS;
          OFF_CLKSEL: begin
            clk_sel = b[1:0];
            presc_phase = 0;
            pit_phase = 0;
          end
          OFF_CNTL, OFF_CNTH: begin
            if (it.reg_offset == OFF_CNTH) count_now[15:8] = b;
            else count_now[7:0] = b;
            cnt_hi_latch = count_now[15:8];
            busy_left[TMR_CNT] = BUSY_TICKS;
            presc_phase = 0;
          end
          OFF_PERL, OFF_PERH: begin
            if (it.reg_offset == OFF_PERH) count_top[15:8] = b;
            else count_top[7:0] = b;
            busy_left[TMR_PER] = BUSY_TICKS;
            presc_phase = 0;
          end
          OFF_CMPL, OFF_CMPH: begin
            if (it.reg_offset == OFF_CMPH) count_cmp[15:8] = b;
            else count_cmp[7:0] = b;
            busy_left[TMR_CMP] = BUSY_TICKS;
            presc_phase = 0;
          end
          OFF_PITCTRLA: begin
            pit_ctrl = b;
            busy_left[TMR_PIT] = BUSY_TICKS;
            pit_phase = 0;
          end
          OFF_PITINTCTRL: pit_en_flag[0] = b[0];
          OFF_PITINTFLAGS: if (b[0]) pit_en_flag[1] = 1'b0;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (it.reg_offset)
          OFF_CTRLA: r.read_byte = ctrl_a;
          OFF_STATUS:
            for (int i = 0; i < 4; i++) r.read_byte[i] = (busy_left[i] != 0);
          OFF_INTCTRL: r.read_byte = {6'd0, irq_enables};
          OFF_INTFLAGS: r.read_byte = {6'd0, irq_flags};
          OFF_CLKSEL: r.read_byte = {6'd0, clk_sel};
          OFF_CNTL: begin
            cnt_hi_latch = count_now[15:8];
            r.read_byte = count_now[7:0];
          end
          OFF_CNTH: r.read_byte = cnt_hi_latch;
          OFF_PERL: r.read_byte = count_top[7:0];
          OFF_PERH: r.read_byte = count_top[15:8];
          OFF_CMPL: r.read_byte = count_cmp[7:0];
          OFF_CMPH: r.read_byte = count_cmp[15:8];
          OFF_PITCTRLA: r.read_byte = pit_ctrl;
          OFF_PITSTATUS: r.read_byte = {7'd0, busy_left[TMR_PIT] != 0};
          OFF_PITINTCTRL: r.read_byte = {7'd0, pit_en_flag[0]};
          OFF_PITINTFLAGS: r.read_byte = {7'd0, pit_en_flag[1]};
          default: r.read_byte = '0;
        endcase
      end
      default: ;
    endcase
    r.counter_irq = |(irq_flags & irq_enables & BOTH_BITS);
    r.periodic_irq = &pit_en_flag;
    return r;
  endfunction

  // idle percentages per traffic phase: sender light, then receiver light, then none
  function automatic int send_idle_pct(input int n);
    if (n < 185) return 16;
    else if (n < 370) return 58;
    else return 0;
  endfunction

  function automatic int recv_idle_pct(input int n);
    if (n < 185) return 58;
    else if (n < 370) return 16;
    else return 0;
  endfunction

  function automatic void queue_item(input logic [1:0] cmd, input logic [4:0] off,
                                     input logic [7:0] b);
    item_t it;
    it.cmd = cmd;
    it.reg_offset = off;
    it.write_byte = b;
    pending_items.push_back(it);
  endfunction

  // random transaction, biased toward small periods and prescalers so the
  // counter and the periodic timer wrap often
  function automatic item_t random_item();
    item_t it;
    int    kind;
    logic [4:0] reg_list [14];
    reg_list = '{OFF_CTRLA, OFF_STATUS, OFF_INTCTRL, OFF_INTFLAGS, OFF_CLKSEL,
                 OFF_CNTL, OFF_CNTH, OFF_PERL, OFF_PERH, OFF_CMPL, OFF_CMPH,
                 OFF_PITCTRLA, OFF_PITINTCTRL, OFF_PITINTFLAGS};
    kind = $urandom_range(99);
    it.write_byte = 8'($urandom);
    if ($urandom_range(99) < 85) it.reg_offset = reg_list[$urandom_range(13)];
    else it.reg_offset = 5'($urandom_range(31));
    if (kind < 50) begin
      it.cmd = CMD_TICK;
    end else if (kind < 80) begin
      it.cmd = CMD_WRITE;
      if ($urandom_range(99) < 80) begin
        case (it.reg_offset)
          OFF_CTRLA: it.write_byte = 8'(($urandom_range(2) << 3) | 1);
          OFF_CNTH, OFF_PERH, OFF_CMPH: it.write_byte = 8'h00;
          OFF_CNTL, OFF_PERL, OFF_CMPL: it.write_byte = 8'($urandom_range(12));
          OFF_PITCTRLA: it.write_byte = 8'(($urandom_range(3, 1) << 3) | 1);
          default: ;
        endcase
      end
    end else if (kind < 97) begin
      it.cmd = CMD_READ;
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  // stimulus, reset and end of run
  initial begin
    rtc_state_reset();
    // reset values, then a short period with compare and a fast periodic timer
    queue_item(CMD_READ, OFF_PERL, 8'h00);
    queue_item(CMD_READ, OFF_PERH, 8'h5a);
    queue_item(CMD_WRITE, OFF_PERL, 8'h03);
    queue_item(CMD_WRITE, OFF_PERH, 8'h00);
    queue_item(CMD_WRITE, OFF_CMPL, 8'h02);
    queue_item(CMD_WRITE, OFF_INTCTRL, 8'hff);
    queue_item(CMD_WRITE, OFF_PITINTCTRL, 8'hff);
    queue_item(CMD_WRITE, OFF_PITCTRLA, 8'h09);
    queue_item(CMD_WRITE, OFF_CTRLA, 8'h01);
    // sync busy right after the writes
    queue_item(CMD_READ, OFF_STATUS, 8'h00);
    queue_item(CMD_READ, OFF_PITSTATUS, 8'h00);
    repeat (5) queue_item(CMD_TICK, OFF_UNUSED_HI, 8'hff);
    queue_item(CMD_READ, OFF_INTFLAGS, 8'h00);
    queue_item(CMD_WRITE, OFF_INTFLAGS, 8'hff);
    queue_item(CMD_WRITE, OFF_PITINTFLAGS, 8'hff);
    // counter beyond top wraps, compare at zero hits on the wrap
    queue_item(CMD_WRITE, OFF_CNTH, 8'hff);
    queue_item(CMD_WRITE, OFF_CMPL, 8'h00);
    queue_item(CMD_TICK, OFF_CTRLA, 8'h00);
    queue_item(CMD_READ, OFF_CNTL, 8'h00);
    queue_item(CMD_READ, OFF_CNTH, 8'h00);
    // compare above top never hits
    queue_item(CMD_WRITE, OFF_CMPH, 8'h01);
    repeat (2) queue_item(CMD_TICK, OFF_CTRLA, 8'h00);
    // clock select, unknown command, unused offsets, slowest prescaler
    queue_item(CMD_WRITE, OFF_CLKSEL, 8'hff);
    queue_item(CMD_READ, OFF_CLKSEL, 8'h00);
    queue_item(CMD_NONE, OFF_CTRLA, 8'hff);
    queue_item(CMD_WRITE, OFF_UNUSED_LO, 8'hff);
    queue_item(CMD_READ, OFF_UNUSED_HI, 8'h00);
    queue_item(CMD_WRITE, OFF_CTRLA, 8'hff);
    repeat (RANDOM_ITEMS) pending_items.push_back(random_item());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // driver: predict on acceptance, then offer the next transaction
  always @(posedge clk) begin : drive
    item_t acc;
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        acc = {in_cmd, in_reg_offset, in_write_byte};
        expected_results.push_back(rtc_apply(acc));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct(n_accepted)) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_cmd <= nxt.cmd;
          in_reg_offset <= nxt.reg_offset;
          in_write_byte <= nxt.write_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back up the pipe
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct(n_accepted));
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result read_byte %0h counter_irq %0b periodic_irq %0b",
                 $time, out_read_byte, out_counter_irq, out_periodic_irq);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_read_byte !== want.read_byte) begin
          $display("%0t: read_byte expected %0h actual %0h",
                   $time, want.read_byte, out_read_byte);
          n_errors++;
        end
        if (out_counter_irq !== want.counter_irq) begin
          $display("%0t: counter_irq expected %0b actual %0b",
                   $time, want.counter_irq, out_counter_irq);
          n_errors++;
        end
        if (out_periodic_irq !== want.periodic_irq) begin
          $display("%0t: periodic_irq expected %0b actual %0b",
                   $time, want.periodic_irq, out_periodic_irq);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
